### src/ipu_pkg.sv
// ============================================================================
// ipu_pkg
// Shared types, constants and the control store for the integer power unit.
// ============================================================================
`default_nettype none

package ipu_pkg;

    // Width of the base, exponent and power fields.
    localparam int DATA_WIDTH = 32;

    // Control store addressing.
    localparam int STEP_W = 2;

    // Datapath operation codes.
    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_SQMUL = 3'd2;
    localparam logic [2:0] OP_FIN   = 3'd3;
    localparam logic [2:0] OP_NEG   = 3'd4;

    // Jump condition codes.
    localparam logic [1:0] COND_NONE   = 2'd0;
    localparam logic [1:0] COND_ALWAYS = 2'd1;
    localparam logic [1:0] COND_E_NEG  = 2'd2;
    localparam logic [1:0] COND_K_NZ   = 2'd3;

    // Step addresses of the microprogram.
    localparam logic [STEP_W-1:0] STEP_LOAD = 2'd0;
    localparam logic [STEP_W-1:0] STEP_LOOP = 2'd1;
    localparam logic [STEP_W-1:0] STEP_FIN  = 2'd2;
    localparam logic [STEP_W-1:0] STEP_NEG  = 2'd3;

    // Input transaction payload.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] base;
        logic signed [DATA_WIDTH-1:0] exponent;
    } ipu_in_t;

    // Result transaction payload.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] power;
        logic                         undefined_case;
    } ipu_out_t;

    // One control word of the microprogram.
    typedef struct packed {
        logic [2:0]        op;
        logic [1:0]        cond;
        logic [STEP_W-1:0] target;
        logic              last;
    } ipu_cw_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic [2:0] op;
    } ipu_ctrl_t;

    // Status flags from the datapath to the sequencer.
    typedef struct packed {
        logic e_neg;
        logic k_nz;
    } ipu_flags_t;

    // Read-only control store: one control word per step.
    function automatic ipu_cw_t ucode_rom(input logic [STEP_W-1:0] step);
        ipu_cw_t cw;
        cw = '0;
        unique case (step)
            STEP_LOAD: cw = '{op: OP_LOAD,  cond: COND_E_NEG, target: STEP_NEG,  last: 1'b0};
            STEP_LOOP: cw = '{op: OP_SQMUL, cond: COND_K_NZ,  target: STEP_LOOP, last: 1'b0};
            STEP_FIN:  cw = '{op: OP_FIN,   cond: COND_NONE,  target: STEP_LOAD, last: 1'b1};
            STEP_NEG:  cw = '{op: OP_NEG,   cond: COND_NONE,  target: STEP_LOAD, last: 1'b1};
            default:   cw = '{op: OP_NOP,   cond: COND_NONE,  target: STEP_LOAD, last: 1'b1};
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

### src/integer_power_unit.sv
// ============================================================================
// integer_power_unit
// Signed integer power with two's complement wraparound, computed by
// square-and-multiply under control of a small microprogram.
// A negative exponent jumps from the load step to the negative-exponent step;
// otherwise the loop step, one squaring and one multiply per exponent bit,
// repeats while exponent bits remain, then the finish step writes the result.
// A new transaction is accepted in the cycle its predecessor's result shows.
// Reset clears the sequencer and the result strobe; the receiver cannot stall.
// ============================================================================
`default_nettype none

module integer_power_unit
    import ipu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire ipu_in_t operands,
    output logic         done,
    output ipu_out_t     result
);

    localparam int W = DATA_WIDTH;

    ipu_ctrl_t  ctrl;
    ipu_flags_t flags;
    logic       accept;

    logic [W-1:0]   base_reg;
    logic [W-1:0]   exp_reg;
    logic [W-1:0]   acc_reg;
    logic [W-1:0]   acc_next;
    logic [W-1:0]   sq_reg;
    logic [W-1:0]   sq_next;
    logic [W-1:0]   k_reg;
    logic [W-1:0]   k_next;
    logic [W-1:0]   power_reg;
    logic [W-1:0]   power_next;
    logic           undef_reg;
    logic           undef_next;
    logic           done_reg;
    logic           done_next;
    logic [2*W-1:0] prod_acc;
    logic [2*W-1:0] prod_sq;
    logic           b_zero;
    logic           b_one;
    logic           b_mone;
    logic           e_zero;

    // Sequencer with the control store.
    ipu_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    assign accept = start && !busy;

    // Operand decode.
    assign b_zero = (base_reg == '0);
    assign b_one  = (base_reg == W'(1));
    assign b_mone = (base_reg == '1);
    assign e_zero = (exp_reg == '0);

    assign flags.e_neg = exp_reg[W-1];
    assign flags.k_nz  = (k_reg != '0);

    // The two multipliers of one square-and-multiply step.
    assign prod_acc = acc_reg * sq_reg;
    assign prod_sq  = sq_reg * sq_reg;

    // Datapath operations selected by the control word.
    always_comb
    begin
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        k_next     = k_reg;
        power_next = power_reg;
        undef_next = undef_reg;
        done_next  = 1'b0;
        case (ctrl.op)
            OP_LOAD:
            begin
                acc_next = W'(1);
                sq_next  = base_reg;
                k_next   = exp_reg;
            end
            OP_SQMUL:
            begin
                if (k_reg[0])
                begin
                    acc_next = prod_acc[W-1:0];
                end
                sq_next = prod_sq[W-1:0];
                k_next  = k_reg >> 1;
            end
            OP_FIN:
            begin
                undef_next = b_zero && e_zero;
                power_next = (b_zero && e_zero) ? '0 : acc_reg;
                done_next  = 1'b1;
            end
            OP_NEG:
            begin
                // Only bases of magnitude one survive a negative exponent.
                undef_next = b_zero;
                if (b_one)
                begin
                    power_next = W'(1);
                end
                else if (b_mone)
                begin
                    power_next = exp_reg[0] ? '1 : W'(1);
                end
                else
                begin
                    power_next = '0;
                end
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Operand and working registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            base_reg <= operands.base;
            exp_reg  <= operands.exponent;
        end
        acc_reg   <= acc_next;
        sq_reg    <= sq_next;
        k_reg     <= k_next;
        power_reg <= power_next;
        undef_reg <= undef_next;
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    assign done                  = done_reg;
    assign result.power          = power_reg;
    assign result.undefined_case = undef_reg;

endmodule

`default_nettype wire

### src/ipu_seq.sv
// ============================================================================
// ipu_seq
// Microcode sequencer: step counter, control store lookup and conditional
// jumps. Runs one program per accepted transaction.
// ============================================================================
`default_nettype none

module ipu_seq
    import ipu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire ipu_flags_t flags,
    output logic            busy,
    output ipu_ctrl_t       ctrl
);

    logic [STEP_W-1:0] pc_reg;
    logic [STEP_W-1:0] pc_next;
    logic              busy_reg;
    logic              busy_next;
    ipu_cw_t           cw;
    logic              cond_true;

    // Fetch the control word for the current step.
    assign cw = ucode_rom(pc_reg);

    // Evaluate the jump condition.
    always_comb
    begin
        unique case (cw.cond)
            COND_NONE:   cond_true = 1'b0;
            COND_ALWAYS: cond_true = 1'b1;
            COND_E_NEG:  cond_true = flags.e_neg;
            COND_K_NZ:   cond_true = flags.k_nz;
            default:     cond_true = 1'b0;
        endcase
    end

    // Next step and busy state.
    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (!busy_reg)
        begin
            pc_next = STEP_LOAD;
            if (start)
            begin
                busy_next = 1'b1;
            end
        end
        else if (cw.last)
        begin
            pc_next   = STEP_LOAD;
            busy_next = 1'b0;
        end
        else if (cond_true)
        begin
            pc_next = cw.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= STEP_LOAD;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

    // Only issue datapath operations while a program runs.
    assign busy    = busy_reg;
    assign ctrl.op = busy_reg ? cw.op : OP_NOP;

endmodule

`default_nettype wire

### src/ipu_checker.sv
// ============================================================================
// ipu_checker
// Port-level checks of the integer power unit, bound to the top level.
// ============================================================================
`default_nettype none

module ipu_checker
    import ipu_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire logic     done,
    input wire ipu_out_t result
);

    // An accepted transaction keeps the unit busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("unit not busy after an accepted transaction");

    // A result only appears once the unit has finished its work.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe outside the end of a transaction");

    // The result strobe is never asserted twice in a row.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // The undefined cases report a zero power.
    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.undefined_case |-> result.power == '0)
        else $error("undefined case with nonzero power");

endmodule

bind integer_power_unit ipu_checker u_ipu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .result   (result)
);

`default_nettype wire

### tb/tb_top.sv
// ============================================================================
// tb_top
// Self-checking testbench for the integer power unit. A table of directed
// transactions covers the field extremes and the undefined and minus-one
// cases, then random transactions follow with random idle bursts. Every
// accepted transaction queues a typed-in or square-and-multiply predicted
// power; each strobed result is checked against the oldest entry.
// ============================================================================
`timescale 1ns / 100ps

module tb_top;

    import ipu_pkg::*;

    localparam logic [DATA_WIDTH-1:0] INT_MIN   = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] INT_MAX   = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MINUS_ONE = '1;

    localparam int N_DIRECTED   = 24;
    localparam int N_RANDOM     = 1750;
    localparam int N_CALM_TAIL  = 250;
    localparam int SETTLE_CYCLES = 40;
    localparam int LIMIT_CYCLES = 400000;

    // One row of the directed table; typed_in marks a hand-written expectation.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] base;
        logic [DATA_WIDTH-1:0] exponent;
        logic                  typed_in;
        logic [DATA_WIDTH-1:0] power;
        logic                  undefined_case;
    } directed_row_t;

    directed_row_t directed_rows [0:N_DIRECTED-1] = '{
        // Zero base: undefined with a zero or negative exponent, zero otherwise.
        '{32'd0,        32'd0,        1'b1, 32'd0,        1'b1},
        '{32'd0,        MINUS_ONE,    1'b1, 32'd0,        1'b1},
        '{32'd0,        INT_MIN,      1'b1, 32'd0,        1'b1},
        '{32'd0,        32'd1,        1'b1, 32'd0,        1'b0},
        // Zero exponent gives one.
        '{32'd5,        32'd0,        1'b1, 32'd1,        1'b0},
        '{INT_MIN,      32'd0,        1'b1, 32'd1,        1'b0},
        '{MINUS_ONE,    32'd0,        1'b1, 32'd1,        1'b0},
        // Negative exponents.
        '{32'd1,        32'hFFFF_FFFB, 1'b1, 32'd1,       1'b0},
        '{32'd1,        INT_MIN,      1'b1, 32'd1,        1'b0},
        '{MINUS_ONE,    MINUS_ONE,    1'b1, MINUS_ONE,    1'b0},
        '{MINUS_ONE,    32'hFFFF_FFFE, 1'b1, 32'd1,       1'b0},
        '{MINUS_ONE,    INT_MIN,      1'b1, 32'd1,        1'b0},
        '{32'd2,        MINUS_ONE,    1'b1, 32'd0,        1'b0},
        '{INT_MIN,      MINUS_ONE,    1'b1, 32'd0,        1'b0},
        '{INT_MAX,      INT_MIN,      1'b1, 32'd0,        1'b0},
        // Positive exponents, with wraparound.
        '{MINUS_ONE,    INT_MAX,      1'b1, MINUS_ONE,    1'b0},
        '{32'd2,        32'd31,       1'b1, INT_MIN,      1'b0},
        '{32'd2,        32'd32,       1'b1, 32'd0,        1'b0},
        '{32'd3,        32'd5,        1'b1, 32'd243,      1'b0},
        '{32'hFFFF_FFFE, 32'd3,       1'b1, 32'hFFFF_FFF8, 1'b0},
        '{INT_MAX,      INT_MAX,      1'b0, 32'd0,        1'b0},
        '{INT_MIN,      INT_MAX,      1'b0, 32'd0,        1'b0},
        '{32'hFFFF_FFFD, 32'd2,       1'b0, 32'd0,        1'b0},
        '{32'h1234_5678, 32'h4000_0000, 1'b0, 32'd0,      1'b0}
    };

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    ipu_in_t  operands;
    logic     done;
    ipu_out_t result;

    ipu_out_t expected_powers [$];
    int       error_count = 0;
    int       cycle_count = 0;

    integer_power_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operands (operands),
        .done     (done),
        .result   (result)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Expected power of one transaction, by square-and-multiply for a positive exponent.
    function automatic ipu_out_t predict_power(ipu_in_t op);
        ipu_out_t              r;
        logic [DATA_WIDTH-1:0] b;
        logic [DATA_WIDTH-1:0] e;
        logic [DATA_WIDTH-1:0] product;
        logic [DATA_WIDTH-1:0] square;
        logic [DATA_WIDTH-1:0] bits_left;
        r = '0;
        b = op.base;
        e = op.exponent;
        if (e == '0)
        begin
            if (b == '0)
                r.undefined_case = 1'b1;
            else
                r.power = 1;
        end
        else if (e[DATA_WIDTH-1])
        begin
            // Only bases of magnitude one survive a negative exponent.
            if (b == '0)
                r.undefined_case = 1'b1;
            else if (b == 1)
                r.power = 1;
            else if (b == MINUS_ONE)
                r.power = e[0] ? MINUS_ONE : 1;
        end
        else
        begin
            product   = 1;
            square    = b;
            bits_left = e;
            for (int n = 0; n < DATA_WIDTH; n++)
            begin
                if (bits_left[0])
                    product = product * square;
                square    = square * square;
                bits_left = bits_left >> 1;
            end
            r.power = product;
        end
        return r;
    endfunction

    // Random operands, weighted toward the interesting corners.
    function automatic ipu_in_t random_operands();
        ipu_in_t op;
        int      small_base;
        small_base  = int'($urandom_range(0, 6)) - 3;
        op.base     = $urandom;
        op.exponent = $urandom;
        case ($urandom_range(0, 9))
            3: op.exponent = $urandom_range(0, 40);
            4: op.base = small_base;
            5:
            begin
                case ($urandom_range(0, 4))
                    0: op.base = '0;
                    1: op.base = 1;
                    2: op.base = MINUS_ONE;
                    3: op.base = INT_MIN;
                    default: op.base = INT_MAX;
                endcase
                op.exponent[DATA_WIDTH-1] = 1'b1;
            end
            6:
            begin
                op.base     = small_base;
                op.exponent = $urandom_range(0, 40);
            end
            7: op.exponent[DATA_WIDTH-1] = 1'b1;
            8:
            begin
                op.base = small_base / 2;
                case ($urandom_range(0, 2))
                    0: op.exponent = '0;
                    1: op.exponent = MINUS_ONE;
                    default: op.exponent = $urandom;
                endcase
            end
            9: op.exponent[DATA_WIDTH-1] = 1'b0;
            default: ;
        endcase
        return op;
    endfunction

    // Present one transaction and hold it until the unit takes it.
    task automatic send_operands(ipu_in_t op, ipu_out_t want);
        @(negedge clk);
        start    = 1'b1;
        operands = op;
        do
            @(posedge clk);
        while (busy);
        expected_powers.push_back(want);
    endtask

    // Random gap on the sender side, with junk on the operand bus.
    task automatic idle_sender(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start    = 1'b0;
            operands = {$urandom, $urandom};
        end
    endtask

    // Hold off until every outstanding result has come back.
    task automatic wait_for_results();
        @(negedge clk);
        start = 1'b0;
        while (expected_powers.size() != 0)
            @(posedge clk);
    endtask

    // Result checker: each strobed result against the oldest expectation.
    always @(posedge clk)
    begin
        ipu_out_t want;
        if (rst_n && done)
        begin
            if (expected_powers.size() == 0)
            begin
                $error("unexpected result: power %0d, undefined_case %0b",
                       $signed(result.power), result.undefined_case);
                error_count++;
            end
            else
            begin
                want = expected_powers.pop_front();
                if (result.power !== want.power)
                begin
                    $error("power: expected %0d, got %0d",
                           $signed(want.power), $signed(result.power));
                    error_count++;
                end
                if (result.undefined_case !== want.undefined_case)
                begin
                    $error("undefined_case: expected %0b, got %0b",
                           want.undefined_case, result.undefined_case);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus.
    initial
    begin
        ipu_in_t  op;
        ipu_out_t want;
        rst_n       = 1'b0;
        start       = 1'b0;
        operands    = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table.
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            op.base     = directed_rows[i].base;
            op.exponent = directed_rows[i].exponent;
            if (directed_rows[i].typed_in)
            begin
                want.power          = directed_rows[i].power;
                want.undefined_case = directed_rows[i].undefined_case;
            end
            else
                want = predict_power(op);
            send_operands(op, want);
            if ($urandom_range(0, 2) == 0)
                idle_sender($urandom_range(1, 13));
        end
        wait_for_results();

        // Random transactions; the tail runs without gaps.
        for (int i = 0; i < N_RANDOM; i++)
        begin
            op = random_operands();
            send_operands(op, predict_power(op));
            if (i == N_RANDOM / 2)
                wait_for_results();
            else if (i < N_RANDOM - N_CALM_TAIL && $urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 13));
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
